FILE: rtl/cbip_pkg.sv
// ----------------------------------------------------------------------------
// cbip_pkg
// Shared types and constants for the custom base integer parser: payload
// structs, alphabet configuration bundle, parse phases and character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cbip_pkg;

   // field and register widths
   localparam int CHAR_W      = 8;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 5;
   localparam int SYM_SLOTS   = 16;
   localparam int DIGIT_W     = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYMBOLS_LOW  = 2'd0,
      CSR_SYMBOLS_HIGH = 2'd1,
      CSR_SYMBOL_COUNT = 2'd2
   } csr_index_type;

   // parse phases
   typedef enum logic [1:0] {
      PH_SPACE  = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGIT  = 2'd2,
      PH_FROZEN = 2'd3
   } phase_type;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_VT    = 8'h0B;
   localparam logic [CHAR_W-1:0] CHAR_FF    = 8'h0C;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   // input item
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } req_type;

   // result item
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      base_invalid;
   } rsp_type;

   // alphabet as seen by the datapath
   typedef struct packed {
      logic [SYM_SLOTS-1:0][CHAR_W-1:0] sym;
      logic [COUNT_W-1:0]               count;
      logic                             invalid;
   } alpha_type;

   // digit lookup result
   typedef struct packed {
      logic               hit;
      logic [DIGIT_W-1:0] value;
   } digit_type;

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_FF) || (c == CHAR_LF) ||
             (c == CHAR_CR) || (c == CHAR_TAB) || (c == CHAR_VT);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/custom_base_integer_parser.sv
// ----------------------------------------------------------------------------
// custom_base_integer_parser
// A last byte is registered at input; its result in the result register.
// Throughput: one byte per cycle unless a last byte meets a stalled full
// result register; byte-to-byte limit is the accumulator multiply-add loop.
// Reset: synchronous, active high; clears alphabet registers (base invalid)
// and the parse state, and empties the input and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module custom_base_integer_parser #(
   parameter int MAX_SYMBOLS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  cbip_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output cbip_pkg::rsp_type                rsp_payload,
   input  logic                             csr_we,
   input  logic [cbip_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cbip_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cbip_pkg::*;

   logic      s1_valid_ff, s1_valid_in;
   req_type   s1_item_ff, s1_item_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_item_ff, rsp_item_in;
   logic      s1_advance, req_xfer, rsp_load;
   alpha_type alpha;
   digit_type digit;
   rsp_type   parse_result;

   cbip_csr #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .alpha     (alpha)
   );

   cbip_digit #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_digit (
      .ch    (s1_item_ff.ch),
      .alpha (alpha),
      .digit (digit)
   );

   cbip_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_advance),
      .item   (s1_item_ff),
      .digit  (digit),
      .alpha  (alpha),
      .result (parse_result)
   );

   // input stage moves on unless a last byte hits a stalled result register
   assign s1_advance = s1_valid_ff && (!s1_item_ff.last || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_xfer   = req_valid && req_ready;
   assign rsp_load   = s1_advance && s1_item_ff.last;

   // next values for input and result registers
   always_comb begin
      s1_valid_in  = req_xfer || (s1_valid_ff && !s1_advance);
      s1_item_in   = req_xfer ? req_payload : s1_item_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_item_in  = rsp_load ? parse_result : rsp_item_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

endmodule

`default_nettype wire

FILE: rtl/cbip_csr.sv
// ----------------------------------------------------------------------------
// cbip_csr
// Alphabet registers and a registered alphabet validity check (count range,
// forbidden symbols, repeated symbols).
// ----------------------------------------------------------------------------
`default_nettype none

module cbip_csr #(
   parameter int MAX_SYMBOLS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [cbip_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cbip_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output cbip_pkg::alpha_type              alpha
);
   import cbip_pkg::*;

   logic [CSR_DATA_W-1:0]            sym_low_ff, sym_low_in;
   logic [CSR_DATA_W-1:0]            sym_high_ff, sym_high_in;
   logic [COUNT_W-1:0]               count_ff, count_in;
   logic                             invalid_ff, invalid_in;
   logic [SYM_SLOTS-1:0][CHAR_W-1:0] sym;

   assign sym = {sym_high_ff, sym_low_ff};

   // register write decode
   always_comb begin
      sym_low_in  = sym_low_ff;
      sym_high_in = sym_high_ff;
      count_in    = count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SYMBOLS_LOW:  sym_low_in  = csr_wdata;
            CSR_SYMBOLS_HIGH: sym_high_in = csr_wdata;
            CSR_SYMBOL_COUNT: count_in    = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // alphabet check over the symbols in use
   always_comb begin
      invalid_in = (count_ff < COUNT_W'(2)) || (count_ff > COUNT_W'(MAX_SYMBOLS));
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         if (COUNT_W'(i) < count_ff) begin
            if ((sym[i] == CHAR_NUL) || (sym[i] == CHAR_PLUS) || (sym[i] == CHAR_MINUS)) begin
               invalid_in = 1'b1;
            end
            for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
               if ((COUNT_W'(j) < count_ff) && (sym[i] == sym[j])) begin
                  invalid_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_low_ff  <= '0;
         sym_high_ff <= '0;
         count_ff    <= '0;
         invalid_ff  <= 1'b1;
      end else begin
         sym_low_ff  <= sym_low_in;
         sym_high_ff <= sym_high_in;
         count_ff    <= count_in;
         invalid_ff  <= invalid_in;
      end
   end

   assign alpha.sym     = sym;
   assign alpha.count   = count_ff;
   assign alpha.invalid = invalid_ff;

endmodule

`default_nettype wire

FILE: rtl/cbip_digit.sv
// ----------------------------------------------------------------------------
// cbip_digit
// Digit lookup: parallel compare of one byte against the symbols in use,
// lowest matching position wins, a zero byte never matches.
// ----------------------------------------------------------------------------
`default_nettype none

module cbip_digit #(
   parameter int MAX_SYMBOLS = 16
) (
   input  logic [cbip_pkg::CHAR_W-1:0] ch,
   input  cbip_pkg::alpha_type         alpha,
   output cbip_pkg::digit_type         digit
);
   import cbip_pkg::*;

   // scan from the top so the lowest hit lands last
   always_comb begin
      digit.hit   = 1'b0;
      digit.value = '0;
      for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
         if ((COUNT_W'(i) < alpha.count) && (alpha.sym[i] == ch) && (ch != CHAR_NUL)) begin
            digit.hit   = 1'b1;
            digit.value = DIGIT_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/cbip_parse.sv
// ----------------------------------------------------------------------------
// cbip_parse
// Parse state (phase, sign, accumulator) and the per-byte update:
// whitespace skip, sign toggling, multiply-add of digits, freeze.
// ----------------------------------------------------------------------------
`default_nettype none

module cbip_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  cbip_pkg::req_type   item,
   input  cbip_pkg::digit_type digit,
   input  cbip_pkg::alpha_type alpha,
   output cbip_pkg::rsp_type   result
);
   import cbip_pkg::*;

   phase_type            phase_ff, phase_in, ph;
   logic                 neg_ff, neg_in, neg;
   logic [VALUE_W-1:0]   acc_ff, acc_in, acc;
   logic [VALUE_W-1:0]   product;

   // accumulator times base
   assign product = acc_ff * {{(VALUE_W-COUNT_W){1'b0}}, alpha.count};

   // one byte through the phases
   always_comb begin
      ph  = phase_ff;
      neg = neg_ff;
      acc = acc_ff;
      if ((ph == PH_SPACE) && !is_space(item.ch)) begin
         ph = PH_SIGN;
      end
      if (ph == PH_SIGN) begin
         if ((item.ch == CHAR_PLUS) || (item.ch == CHAR_MINUS)) begin
            if (item.ch == CHAR_MINUS) begin
               neg = ~neg;
            end
         end else begin
            ph = PH_DIGIT;
         end
      end
      if (ph == PH_DIGIT) begin
         if (!digit.hit) begin
            ph = PH_FROZEN;
         end else begin
            acc = product + {{(VALUE_W-DIGIT_W){1'b0}}, digit.value};
         end
      end
   end

   // result for a last byte
   always_comb begin
      result.base_invalid = alpha.invalid;
      if (alpha.invalid) begin
         result.value = '0;
      end else if (neg) begin
         result.value = VALUE_W'(0) - acc;
      end else begin
         result.value = acc;
      end
   end

   // state clears after a last byte
   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      if (fire) begin
         if (item.last) begin
            phase_in = PH_SPACE;
            neg_in   = 1'b0;
            acc_in   = '0;
         end else begin
            phase_in = ph;
            neg_in   = neg;
            acc_in   = acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SPACE;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/cbip_checker.sv
// ----------------------------------------------------------------------------
// cbip_checker
// Port-level checks for the custom base integer parser, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module cbip_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input cbip_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cbip_pkg::rsp_type rsp_payload
);
   import cbip_pkg::*;

   // result register is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // invalid alphabet always reports zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.base_invalid |-> rsp_payload.value == '0)
      else $error("invalid base with nonzero value");

   // a fresh result follows a last byte transfer via the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_payload.last && !reset, 2))
      else $error("result without a last byte");

   // with no result pending the input side never stalls
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

endmodule

bind custom_base_integer_parser cbip_checker u_cbip_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

FILE: sim/custom_base_integer_parser_test.sv
// ----------------------------------------------------------------------------
// custom_base_integer_parser_test
// Self-checking bench for the base-alphabet integer parser. A short table of
// characters covers whitespace, sign runs, the 32-bit minimum and freezing
// bytes. Random strings follow under a series of alphabets, valid and broken,
// with sender gaps and receiver stalls. Every result is checked against a
// cycle-free model of the parse kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module custom_base_integer_parser_test;

   timeunit 1ns;
   timeprecision 1ps;

   import cbip_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   localparam int RESET_CYCLES  = 5;
   localparam int DRAIN_CYCLES  = 4;
   localparam int TIMEOUT_NS    = 5_000_000;
   localparam int DIRECTED_ROWS = 24;
   localparam int HEX_FIRST_ROW = 1;
   localparam int PHASES        = 14;
   localparam int GOOD_BUDGET   = 170;
   localparam int BAD_BUDGET    = 60;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // how each phase builds its alphabet
   typedef enum logic [2:0] {
      ALPHA_FIXED, ALPHA_ANY, ALPHA_SHORT, ALPHA_LONG, ALPHA_DUP, ALPHA_NUL, ALPHA_SIGN
   } alpha_kind_type;

   typedef struct packed {
      alpha_kind_type     kind;
      logic [COUNT_W-1:0] count;
   } alpha_plan_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  ch;
      logic               last;
      logic               typed;
      logic [VALUE_W-1:0] value;
      logic               invalid;
   } char_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   idle_mode_type idle_mode = IDLE_NONE;
   int            mismatch_count = 0;
   rsp_type       pending_values [$];

   // shadow registers and parse state
   logic [CSR_DATA_W-1:0] shadow_low = '0;
   logic [CSR_DATA_W-1:0] shadow_high = '0;
   logic [COUNT_W-1:0]    shadow_count = '0;
   phase_type             parse_phase = PH_SPACE;
   logic                  parse_negative = 1'b0;
   logic [VALUE_W-1:0]    parse_acc = '0;

   logic [CHAR_W-1:0] blank_chars [6] = '{CHAR_SPACE, CHAR_FF, CHAR_LF, CHAR_CR, CHAR_TAB, CHAR_VT};

   // directed characters; row 0 runs on the reset alphabet, the rest on hex
   char_row_type directed_text [DIRECTED_ROWS] = '{
      '{"7",        1'b1, 1'b1, 32'h0000_0000, 1'b1},
      '{CHAR_TAB,   1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{CHAR_VT,    1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{CHAR_SPACE, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{CHAR_LF,    1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{CHAR_CR,    1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{CHAR_FF,    1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{CHAR_MINUS, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{CHAR_PLUS,  1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{"8",        1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{"0",        1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{"0",        1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{"0",        1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{"0",        1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{"0",        1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{"0",        1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{"0",        1'b1, 1'b1, 32'h8000_0000, 1'b0},
      '{"1",        1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{CHAR_NUL,   1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{"5",        1'b1, 1'b1, 32'h0000_0001, 1'b0},
      '{CHAR_MINUS, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{"G",        1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{"F",        1'b1, 1'b1, 32'h0000_0000, 1'b0},
      '{8'hFF,      1'b1, 1'b1, 32'h0000_0000, 1'b0}
   };

   alpha_plan_type phase_plan [PHASES] = '{
      '{ALPHA_FIXED, 5'd16}, '{ALPHA_FIXED, 5'd2},  '{ALPHA_SHORT, 5'd0},
      '{ALPHA_ANY,   5'd0},  '{ALPHA_LONG,  5'd31}, '{ALPHA_DUP,   5'd0},
      '{ALPHA_ANY,   5'd0},  '{ALPHA_FIXED, 5'd16}, '{ALPHA_NUL,   5'd0},
      '{ALPHA_ANY,   5'd0},  '{ALPHA_SIGN,  5'd0},  '{ALPHA_FIXED, 5'd10},
      '{ALPHA_SHORT, 5'd1},  '{ALPHA_LONG,  5'd17}
   };

   custom_base_integer_parser u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // alphabet lookups on the shadow registers
   function automatic logic [CHAR_W-1:0] alpha_symbol(input int pos);
      return (pos < 8) ? shadow_low[pos*8 +: 8] : shadow_high[(pos-8)*8 +: 8];
   endfunction

   function automatic logic alpha_bad();
      logic [CHAR_W-1:0] s;
      if (shadow_count < 2 || shadow_count > SYM_SLOTS)
         return 1'b1;
      for (int i = 0; i < shadow_count; i++) begin
         s = alpha_symbol(i);
         if (s == CHAR_NUL || s == CHAR_PLUS || s == CHAR_MINUS)
            return 1'b1;
         for (int j = i + 1; j < shadow_count; j++)
            if (alpha_symbol(j) == s)
               return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      foreach (blank_chars[i])
         if (c == blank_chars[i])
            return 1'b1;
      return 1'b0;
   endfunction

   function automatic int used_symbols();
      return (shadow_count > SYM_SLOTS) ? SYM_SLOTS : int'(shadow_count);
   endfunction

   // position of c in the alphabet, lowest wins, -1 when no digit
   function automatic int digit_pos(input logic [CHAR_W-1:0] c);
      if (c == CHAR_NUL)
         return -1;
      for (int i = 0; i < used_symbols(); i++)
         if (alpha_symbol(i) == c)
            return i;
      return -1;
   endfunction

   // advance the parse by one character; returns 1 with the value on a last
   function automatic logic parse_byte(input req_type item, output rsp_type res);
      logic taken;
      int   d;
      taken = 1'b0;
      res = '0;
      if (parse_phase == PH_SPACE) begin
         if (is_blank(item.ch))
            taken = 1'b1;
         else
            parse_phase = PH_SIGN;
      end
      if (!taken && parse_phase == PH_SIGN) begin
         if (item.ch == CHAR_PLUS || item.ch == CHAR_MINUS) begin
            if (item.ch == CHAR_MINUS)
               parse_negative = ~parse_negative;
            taken = 1'b1;
         end else begin
            parse_phase = PH_DIGIT;
         end
      end
      if (!taken && parse_phase == PH_DIGIT) begin
         d = digit_pos(item.ch);
         if (d < 0)
            parse_phase = PH_FROZEN;
         else
            parse_acc = parse_acc * {27'd0, shadow_count} + VALUE_W'(d);
      end
      if (!item.last)
         return 1'b0;
      res.base_invalid = alpha_bad();
      res.value = res.base_invalid ? '0 : (parse_negative ? -parse_acc : parse_acc);
      parse_phase = PH_SPACE;
      parse_negative = 1'b0;
      parse_acc = '0;
      return 1'b1;
   endfunction

   function automatic int sender_idle_pct();
      return (idle_mode == IDLE_SENDER) ? 63 : (idle_mode == IDLE_BOTH) ? 19 : 0;
   endfunction

   function automatic int receiver_stall_pct();
      return (idle_mode == IDLE_RECEIVER) ? 63 : (idle_mode == IDLE_BOTH) ? 19 : 0;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // one character transfer, with an optional gap in front
   task automatic send_char(input req_type item, input logic typed, input rsp_type typed_rsp);
      int      pct;
      rsp_type want;
      pct = sender_idle_pct();
      if (pct != 0 && $urandom_range(0, 99) < pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < pct);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      if (parse_byte(item, want))
         pending_values.push_back(typed ? typed_rsp : want);
   endtask

   // wait for all results, then let the pipeline empty
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_values.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // back-to-back register writes, plus one to the unused index
   task automatic program_alphabet(input logic [CSR_DATA_W-1:0] lo,
                                   input logic [CSR_DATA_W-1:0] hi,
                                   input logic [COUNT_W-1:0] cnt);
      logic [CSR_DATA_W-1:0] count_word;
      count_word = {$urandom, $urandom};
      count_word[COUNT_W-1:0] = cnt;
      csr_we    <= 1'b1;
      csr_index <= CSR_SYMBOLS_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      shadow_low = lo;
      csr_index <= CSR_SYMBOLS_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      shadow_high = hi;
      csr_index <= CSR_SYMBOL_COUNT;
      csr_wdata <= count_word;
      @(posedge clock);
      shadow_count = cnt;
      csr_index <= CSR_UNUSED_INDEX;
      csr_wdata <= {$urandom, $urandom};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // kind's alphabet; unless short, in-use symbols start distinct legal bytes
   task automatic make_alphabet(input alpha_plan_type plan,
                                output logic [CSR_DATA_W-1:0] lo,
                                output logic [CSR_DATA_W-1:0] hi,
                                output logic [COUNT_W-1:0] cnt);
      logic [CHAR_W-1:0] sym [SYM_SLOTS];
      logic [255:0]      taken;
      logic [CHAR_W-1:0] b;
      int                n, i, j;
      taken = '0;
      foreach (sym[k])
         sym[k] = CHAR_W'($urandom);
      if (plan.kind == ALPHA_FIXED || plan.kind == ALPHA_SHORT || plan.kind == ALPHA_LONG)
         cnt = plan.count;
      else
         cnt = COUNT_W'($urandom_range(2, SYM_SLOTS));
      n = (cnt > SYM_SLOTS) ? SYM_SLOTS : int'(cnt);
      if (plan.kind != ALPHA_SHORT) begin
         for (int k = 0; k < n; k++) begin
            do begin
               b = $urandom_range(0, 1) ? CHAR_W'($urandom_range(33, 126))
                                        : CHAR_W'($urandom_range(1, 255));
            end while (b == CHAR_PLUS || b == CHAR_MINUS || taken[b]);
            taken[b] = 1'b1;
            sym[k] = b;
         end
      end
      case (plan.kind)
         ALPHA_DUP: begin
            i = $urandom_range(1, n - 1);
            j = $urandom_range(0, i - 1);
            sym[i] = sym[j];
         end
         ALPHA_NUL: begin
            sym[$urandom_range(0, n - 1)] = CHAR_NUL;
         end
         ALPHA_SIGN: begin
            sym[$urandom_range(0, n - 1)] = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
         end
         default: ;
      endcase
      for (int k = 0; k < 8; k++) begin
         lo[k*8 +: 8] = sym[k];
         hi[k*8 +: 8] = sym[k+8];
      end
   endtask

   // mostly well-formed numbers, some junk strings; may stop mid-string
   task automatic send_string(ref int budget);
      logic [CHAR_W-1:0] text [$];
      int                used;
      req_type           item;
      used = used_symbols();
      if ($urandom_range(0, 99) < 85) begin
         repeat ($urandom_range(0, 3))
            text.push_back(blank_chars[$urandom_range(0, 5)]);
         repeat ($urandom_range(0, 3))
            text.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
         repeat ($urandom_range(1, (used <= 4) ? 36 : 12))
            text.push_back((used == 0) ? CHAR_W'($urandom)
                                       : alpha_symbol($urandom_range(0, used - 1)));
         if ($urandom_range(0, 99) < 30) begin
            text.push_back(CHAR_W'($urandom));
            repeat ($urandom_range(0, 3))
               text.push_back(CHAR_W'($urandom));
         end
      end else begin
         repeat ($urandom_range(1, 8))
            text.push_back(CHAR_W'($urandom));
      end
      foreach (text[k]) begin
         if (budget == 0)
            break;
         item.ch   = text[k];
         item.last = (k == text.size() - 1);
         send_char(item, 1'b0, '0);
         budget--;
      end
   endtask

   // result side: random stalls and the in-order check
   always @(posedge clock) begin : result_check
      rsp_type want;
      rsp_ready <= !(receiver_stall_pct() != 0 && $urandom_range(0, 99) < receiver_stall_pct());
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_values.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d", rsp_payload.value));
         end else begin
            want = pending_values.pop_front();
            if (rsp_payload.value !== want.value)
               report_mismatch($sformatf("value %0d, predicted %0d",
                                         rsp_payload.value, want.value));
            if (rsp_payload.base_invalid !== want.base_invalid)
               report_mismatch($sformatf("base_invalid %0b, predicted %0b",
                                         rsp_payload.base_invalid, want.base_invalid));
         end
      end
   end

   // main sequence
   initial begin : stimulus
      logic [CSR_DATA_W-1:0] lo, hi;
      logic [COUNT_W-1:0]    cnt;
      int                    budget;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table, hex alphabet after the first row
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (i == HEX_FIRST_ROW) begin
            drain();
            program_alphabet("76543210", "FEDCBA98", 5'd16);
         end
         send_char(req_type'({directed_text[i].ch, directed_text[i].last}),
                   directed_text[i].typed,
                   rsp_type'({directed_text[i].value, directed_text[i].invalid}));
      end

      // random phases, one alphabet and idle pattern each
      for (int p = 0; p < PHASES; p++) begin
         drain();
         idle_mode = idle_mode_type'(p % 4);
         make_alphabet(phase_plan[p], lo, hi, cnt);
         program_alphabet(lo, hi, cnt);
         budget = (phase_plan[p].kind inside {ALPHA_FIXED, ALPHA_ANY}) ? GOOD_BUDGET
                                                                       : BAD_BUDGET;
         while (budget > 0)
            send_string(budget);
      end

      drain();
      if (mismatch_count == 0)
         $display("custom_base_integer_parser_test: PASS");
      else
         $display("custom_base_integer_parser_test: FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("custom_base_integer_parser_test: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
